FILE: src/scalar_kalman_filter_defines.svh
// assertion macros shared by the kalman filter rtl
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// same-cycle implication, checked on aclk, off during reset
`define SKF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked on aclk, off during reset
`define SKF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/skf_pkg.sv
// shared types and constants for the scalar kalman filter
package skf_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VARIANCE  = 3'd3;

    // register reset values, truncated to the data width where it is narrower
    localparam logic [31:0] PROCESS_NOISE_RST     = 32'd3277;
    localparam logic [31:0] MEASUREMENT_NOISE_RST = 32'd16384;
    localparam logic [31:0] INITIAL_ESTIMATE_RST  = 32'd65536;
    localparam logic [31:0] INITIAL_VARIANCE_RST  = 32'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DEN,
        ST_INNOV,
        ST_NEG,
        ST_DIV,
        ST_MULX,
        ST_UPDX,
        ST_MULV,
        ST_FIN
    } skf_state_t;

endpackage

FILE: src/scalar_kalman_filter.sv
// scalar kalman filter top level: sequencer around one shared add/subtract unit
//
// usage: measurements arrive on the s_ channel, one item per sample; each item
// runs predict (prior = variance + process noise, saturating) and update, and
// leaves one result item on the m_ channel with estimate, variance and gain.
// all arithmetic goes through a single add/subtract unit: the gain comes from
// a restoring divider at one quotient bit per cycle, the two products from
// shift-add multiplies at one multiplier bit per cycle.
// when the gain is zero or one the divider is skipped. s_tready is high only
// while the sequencer is idle, so a new item is not accepted until the
// previous one has left the last sequencer step.
// the result sits in an output register; while the receiver stalls a finished
// item waits in the last sequencer step if that register is still full, and
// s_tready stays low.
// configuration: cfg_we writes register cfg_index; any valid index reloads the
// estimate and variance from the initial registers. write only while idle.
// reset (aresetn low, synchronous) loads the default registers, reloads the
// state and drops m_tvalid.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [DATA_WIDTH-1:0]         cfg_data,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // measurement
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // estimate, variance_out, gain
    output logic [((2*DATA_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] m_tdata
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = W + F + 2;
    localparam int CW  = $clog2(F + 1);
    localparam int MDW = ((2*W + F + 1 + 7) / 8) * 8;

    localparam logic [PW-1:0] HALF  = PW'(1) << (F - 1);
    localparam logic [F:0]    ONE_G = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0]  EST_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  EST_MIN = {1'b1, {(W-1){1'b0}}};

    skf_state_t state_reg, state_next;

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  x0_reg, x0_next;
    logic [W-1:0]  v0_reg, v0_next;
    logic [W-1:0]  est_reg, est_next;
    logic [W-1:0]  var_reg, var_next;

    logic [W-1:0]  z_reg, z_next;
    logic [W-1:0]  prior_reg, prior_next;
    logic [W:0]    den_reg, den_next;
    logic [W:0]    innov_reg, innov_next;
    logic [W:0]    mag_reg, mag_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [F:0]    g_reg, g_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic          m_valid_reg, m_valid_next;
    logic [W-1:0]  m_est_reg, m_est_next;
    logic [W-1:0]  m_var_reg, m_var_next;
    logic [F:0]    m_gain_reg, m_gain_next;

    // shared arithmetic unit
    logic [PW-1:0] unit_a, unit_b;
    logic          unit_sub;
    logic [PW:0]   unit_res;
    logic          borrow;
    logic [F:0]    mult_bits;
    logic [W:0]    upd_res;

    assign unit_res = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
                               : ({1'b0, unit_a} + {1'b0, unit_b});
    assign borrow    = unit_res[PW];
    assign mult_bits = (state_reg == ST_MULV) ? (ONE_G - g_reg) : g_reg;
    assign upd_res   = unit_res[W:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDW'({m_gain_reg, m_var_reg, m_est_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            q_reg       <= W'(PROCESS_NOISE_RST);
            r_reg       <= W'(MEASUREMENT_NOISE_RST);
            x0_reg      <= W'(INITIAL_ESTIMATE_RST);
            v0_reg      <= W'(INITIAL_VARIANCE_RST);
            est_reg     <= W'(INITIAL_ESTIMATE_RST);
            var_reg     <= W'(INITIAL_VARIANCE_RST);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            q_reg       <= q_next;
            r_reg       <= r_next;
            x0_reg      <= x0_next;
            v0_reg      <= v0_next;
            est_reg     <= est_next;
            var_reg     <= var_next;
        end
        z_reg      <= z_next;
        prior_reg  <= prior_next;
        den_reg    <= den_next;
        innov_reg  <= innov_next;
        mag_reg    <= mag_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        g_reg      <= g_next;
        cnt_reg    <= cnt_next;
        m_est_reg  <= m_est_next;
        m_var_reg  <= m_var_next;
        m_gain_reg <= m_gain_next;
    end

    always_comb begin
        state_next   = state_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        x0_next      = x0_reg;
        v0_next      = v0_reg;
        est_next     = est_reg;
        var_next     = var_reg;
        z_next       = z_reg;
        prior_next   = prior_reg;
        den_next     = den_reg;
        innov_next   = innov_reg;
        mag_next     = mag_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        g_next       = g_reg;
        cnt_next     = cnt_reg;
        m_est_next   = m_est_reg;
        m_var_next   = m_var_reg;
        m_gain_next  = m_gain_reg;
        m_valid_next = m_valid_reg;
        unit_a       = '0;
        unit_b       = '0;
        unit_sub     = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    z_next     = s_tdata[W-1:0];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // prior variance, saturating
                unit_a     = {{(PW-W){1'b0}}, var_reg};
                unit_b     = {{(PW-W){1'b0}}, q_reg};
                prior_next = unit_res[W] ? {W{1'b1}} : unit_res[W-1:0];
                state_next = ST_DEN;
            end
            ST_DEN: begin
                unit_a     = {{(PW-W){1'b0}}, prior_reg};
                unit_b     = {{(PW-W){1'b0}}, r_reg};
                den_next   = unit_res[W:0];
                state_next = ST_INNOV;
            end
            ST_INNOV: begin
                unit_a     = {{(PW-W){z_reg[W-1]}}, z_reg};
                unit_b     = {{(PW-W){est_reg[W-1]}}, est_reg};
                unit_sub   = 1'b1;
                innov_next = unit_res[W:0];
                state_next = ST_NEG;
            end
            ST_NEG: begin
                // magnitude of the innovation
                unit_b   = {{(PW-W-1){innov_reg[W]}}, innov_reg};
                unit_sub = innov_reg[W];
                mag_next = unit_res[W:0];
                cnt_next = '0;
                if (den_reg == '0) begin
                    g_next     = '0;
                    acc_next   = HALF;
                    mcand_next = {{(PW-W-1){1'b0}}, unit_res[W:0]};
                    state_next = ST_MULX;
                end else if (r_reg == '0) begin
                    // prior reaches the denominator: gain is exactly one
                    g_next     = ONE_G;
                    acc_next   = HALF;
                    mcand_next = {{(PW-W-1){1'b0}}, unit_res[W:0]};
                    state_next = ST_MULX;
                end else begin
                    g_next     = '0;
                    acc_next   = {{(PW-W){1'b0}}, prior_reg};
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one restoring quotient bit per cycle
                unit_a   = {acc_reg[PW-2:0], 1'b0};
                unit_b   = {{(PW-W-1){1'b0}}, den_reg};
                unit_sub = 1'b1;
                acc_next = borrow ? unit_a : unit_res[PW-1:0];
                g_next   = {g_reg[F-1:0], !borrow};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(F - 1)) begin
                    acc_next   = HALF;
                    mcand_next = {{(PW-W-1){1'b0}}, mag_reg};
                    cnt_next   = '0;
                    state_next = ST_MULX;
                end
            end
            ST_MULX, ST_MULV: begin
                unit_a     = acc_reg;
                unit_b     = mult_bits[cnt_reg] ? mcand_reg : '0;
                acc_next   = unit_res[PW-1:0];
                mcand_next = {mcand_reg[PW-2:0], 1'b0};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(F)) begin
                    state_next = (state_reg == ST_MULX) ? ST_UPDX : ST_FIN;
                end
            end
            ST_UPDX: begin
                // move the estimate by the rounded delta toward the measurement
                unit_a   = {{(PW-W){est_reg[W-1]}}, est_reg};
                unit_b   = PW'(acc_reg[PW-1:F]);
                unit_sub = innov_reg[W];
                if (upd_res[W] != upd_res[W-1]) begin
                    est_next = upd_res[W] ? EST_MIN : EST_MAX;
                end else begin
                    est_next = upd_res[W-1:0];
                end
                acc_next   = HALF;
                mcand_next = {{(PW-W){1'b0}}, prior_reg};
                cnt_next   = '0;
                state_next = ST_MULV;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    var_next     = acc_reg[W+F-1:F];
                    m_est_next   = est_reg;
                    m_var_next   = acc_reg[W+F-1:F];
                    m_gain_next  = g_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // the user writes registers only while idle, which the block does not enforce; a valid index reloads the state
        if (cfg_we) begin
            unique case (cfg_index)
                REG_PROCESS_NOISE:     q_next  = cfg_data;
                REG_MEASUREMENT_NOISE: r_next  = cfg_data;
                REG_INITIAL_ESTIMATE:  x0_next = cfg_data;
                REG_INITIAL_VARIANCE:  v0_next = cfg_data;
                default: ;
            endcase
            if (cfg_index == REG_PROCESS_NOISE || cfg_index == REG_MEASUREMENT_NOISE ||
                cfg_index == REG_INITIAL_ESTIMATE || cfg_index == REG_INITIAL_VARIANCE) begin
                est_next = x0_next;
                var_next = v0_next;
            end
        end
    end

    `SKF_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_PREP, "item accepted but predict did not start")
    `SKF_ASSERT_NOW(a_gain_range, m_valid_reg, m_gain_reg <= ONE_G, "gain above one")
    `SKF_ASSERT_NOW(a_var_bound, state_reg == ST_FIN, (acc_reg >> F) <= PW'(prior_reg), "variance exceeds prior")
    `SKF_ASSERT_NOW(a_div_den, state_reg == ST_DIV, den_reg != '0 && r_reg != '0, "divider running on a special case")

endmodule
